FILE: rtl/core/bba_pkg.sv
// Shared constants, types and helpers for the bitmap block allocator.
package bba_pkg;

  localparam int MAP_BITS  = 1024;
  localparam int WORD_BITS = (MAP_BITS < 32) ? MAP_BITS : 32;
  localparam int OFF_W     = $clog2(WORD_BITS);
  localparam int WORDS     = MAP_BITS / WORD_BITS;
  localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int MAP_LG    = $clog2(MAP_BITS);
  localparam int PW        = ((MAP_LG > 12) ? MAP_LG : 12) + 1;

  localparam int CNT_W = 11;
  localparam int IDX_W = 10;
  localparam int ST_W  = 2;
  localparam int LG_W  = 5;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADREQ  = 2'd2
  } status_t;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic             is_free;
    logic [LG_W-1:0]  lg;
    logic [OFF_W-1:0] lo_off;
    logic [OFF_W-1:0] hi_off;
  } wu_ctl_t;

  typedef struct packed {
    logic             hit;
    logic             zero;
    logic [OFF_W-1:0] pos;
  } wu_sts_t;

  // ceil(log2(c)) for c >= 1
  function automatic logic [LG_W-1:0] ceil_lg(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] m;
    m = c - CNT_W'(1);
    ceil_lg = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (m[i]) ceil_lg = LG_W'(i + 1);
    end
  endfunction

endpackage

FILE: rtl/core/bba_if.sv
// Request and response channel interfaces of the bitmap block allocator.
interface bba_req_if;
  import bba_pkg::*;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [CNT_W-1:0] page_count;
  logic [IDX_W-1:0] start_index;
  modport source (output valid, req_type, page_count, start_index, input ready);
  modport sink   (input valid, req_type, page_count, start_index, output ready);
endinterface

interface bba_rsp_if;
  import bba_pkg::*;
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [IDX_W-1:0] block_index;
  modport source (output valid, status, block_index, input ready);
  modport sink   (input valid, status, block_index, output ready);
endinterface

FILE: rtl/core/bba_ram.sv
// Generic single-port-write, registered-read RAM.
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/bba_word_unit.sv
// Per-word allocate search and set/clear mask unit.
module bba_word_unit (
  input  bba_pkg::word_t   rd_word,
  input  bba_pkg::wu_ctl_t ctl,
  output bba_pkg::word_t   wr_word,
  output bba_pkg::wu_sts_t sts
);
  import bba_pkg::*;

  word_t            lvl [OFF_W+1];
  word_t            sel;
  word_t            amask;
  word_t            fmask;
  logic [OFF_W:0]   len_w;
  logic [OFF_W-1:0] gi;
  logic             hit;

  // free-group folding: lvl[k][i] set when aligned group i of 2^k pages is clear
  always_comb begin
    lvl[0] = ~rd_word;
    for (int k = 1; k <= OFF_W; k++) begin
      lvl[k] = '0;
      for (int i = 0; i < (WORD_BITS >> k); i++) begin
        lvl[k][i] = lvl[k-1][2*i] & lvl[k-1][2*i+1];
      end
    end
  end

  always_comb begin
    sel = '0;
    for (int k = 0; k <= OFF_W; k++) begin
      if (ctl.lg == LG_W'(k)) sel = lvl[k];
    end
    hit = 1'b0;
    gi  = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (sel[i]) begin
        hit = 1'b1;
        gi  = OFF_W'(i);
      end
    end
  end

  assign len_w   = (OFF_W+1)'(1) << ctl.lg;
  assign sts.hit  = hit;
  assign sts.pos  = gi << ctl.lg;
  assign sts.zero = (rd_word == '0);

  assign amask = (~({WORD_BITS{1'b1}} << len_w)) << sts.pos;
  assign fmask = ({WORD_BITS{1'b1}} << ctl.lo_off) & ({WORD_BITS{1'b1}} >> (~ctl.hi_off));

  assign wr_word = ctl.is_free ? (rd_word & ~fmask) : (rd_word | amask);

endmodule

FILE: rtl/core/bitmap_block_allocator_core.sv
// Bitmap block allocator: top level with request sequencer and page bitmap RAM.
//
// Keeps one used bit per page in a RAM of 32-bit words; each word is visited by a
// read state, then an evaluate and write-back state. After reset a clearing pass
// writes every word with in_req.ready low. Allocate scans from word 0 for a free
// aligned block, then fills word by word a block longer than a word; free reads
// and writes back each word touched; zero-count and oversize requests go straight
// to the done state. One request is in flight at a time; a finished response
// waits in the output register while the next request may already be taken.
module bitmap_block_allocator_core (
  input logic      clk,
  input logic      rst_n,
  bba_req_if.sink  in_req,
  bba_rsp_if.source out_rsp
);
  import bba_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EVAL,
    S_FILL,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    word_r, word_nxt;
  logic             kind_r, kind_nxt;
  logic [LG_W-1:0]  lg_r, lg_nxt;
  logic [AW-1:0]    first_word_r, first_word_nxt;
  logic [OFF_W-1:0] first_off_r, first_off_nxt;
  logic [AW-1:0]    hi_word_r, hi_word_nxt;
  logic [OFF_W-1:0] last_off_r, last_off_nxt;
  logic             last_in_map_r, last_in_map_nxt;
  logic             ok_r, ok_nxt;
  logic [AW-1:0]    fill_end_r, fill_end_nxt;
  status_t          res_status_r, res_status_nxt;
  logic [IDX_W-1:0] res_index_r, res_index_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [IDX_W-1:0] out_index_r, out_index_nxt;

  logic             ram_we;
  word_t            ram_wdata;
  word_t            ram_rdata;
  word_t            wu_wdata;
  wu_ctl_t          wu_ctl;
  wu_sts_t          wu_sts;

  logic             accept;
  logic [LG_W-1:0]  in_lg;
  logic [PW-1:0]    start_pw;
  logic [PW-1:0]    last_pw;
  logic [PW-1:0]    first_w_pw;
  logic [PW-1:0]    last_w_pw;
  logic [AW-1:0]    blk_mask;
  logic [AW-1:0]    blk_start;
  logic [MAP_LG-1:0] hit_pos;
  logic [MAP_LG-1:0] blk_pos;
  logic             last_word;
  logic             in_word;

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (word_r),
    .wdata (ram_wdata),
    .raddr (word_r),
    .rdata (ram_rdata)
  );

  bba_word_unit u_word_unit (
    .rd_word (ram_rdata),
    .ctl     (wu_ctl),
    .wr_word (wu_wdata),
    .sts     (wu_sts)
  );

  assign accept = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == S_IDLE);

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.block_index = out_index_r;

  assign in_lg      = ceil_lg(in_req.page_count);
  assign start_pw   = PW'(in_req.start_index);
  assign last_pw    = start_pw + (PW'(1) << in_lg) - PW'(1);
  assign first_w_pw = start_pw >> OFF_W;
  assign last_w_pw  = last_pw >> OFF_W;

  assign wu_ctl.is_free = (kind_r == REQ_FREE);
  assign wu_ctl.lg      = lg_r;
  assign wu_ctl.lo_off  = (word_r == first_word_r) ? first_off_r : '0;
  assign wu_ctl.hi_off  = (last_in_map_r && word_r == hi_word_r) ? last_off_r : '1;

  assign in_word   = (lg_r <= LG_W'(OFF_W));
  assign last_word = (word_r == AW'(WORDS - 1));
  assign blk_mask  = ~({AW{1'b1}} << (lg_r - LG_W'(OFF_W)));
  assign blk_start = word_r & ~blk_mask;
  assign hit_pos   = {word_r, wu_sts.pos};
  assign blk_pos   = {blk_start, {OFF_W{1'b0}}};

  always_comb begin
    state_nxt       = state_r;
    word_nxt        = word_r;
    kind_nxt        = kind_r;
    lg_nxt          = lg_r;
    first_word_nxt  = first_word_r;
    first_off_nxt   = first_off_r;
    hi_word_nxt     = hi_word_r;
    last_off_nxt    = last_off_r;
    last_in_map_nxt = last_in_map_r;
    ok_nxt          = ok_r;
    fill_end_nxt    = fill_end_r;
    res_status_nxt  = res_status_r;
    res_index_nxt   = res_index_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_index_nxt   = out_index_r;
    ram_we          = 1'b0;
    ram_wdata       = wu_wdata;

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (last_word) begin
          state_nxt = S_IDLE;
        end else begin
          word_nxt = word_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          kind_nxt        = in_req.req_type;
          lg_nxt          = in_lg;
          first_word_nxt  = AW'(first_w_pw);
          first_off_nxt   = start_pw[OFF_W-1:0];
          last_off_nxt    = last_pw[OFF_W-1:0];
          last_in_map_nxt = (last_w_pw < PW'(WORDS));
          hi_word_nxt     = (last_w_pw < PW'(WORDS)) ? AW'(last_w_pw) : AW'(WORDS - 1);
          ok_nxt          = 1'b1;
          res_status_nxt  = ST_OK;
          res_index_nxt   = '0;
          state_nxt       = S_RD;
          if (in_req.page_count == '0) begin
            res_status_nxt = ST_BADREQ;
            state_nxt      = S_DONE;
          end else if (in_req.req_type == REQ_ALLOC) begin
            word_nxt = '0;
            if (in_lg >= LG_W'(MAP_LG - 1)) begin
              res_status_nxt = ST_NOSPACE;
              state_nxt      = S_DONE;
            end
          end else begin
            word_nxt = AW'(first_w_pw);
            if (first_w_pw >= PW'(WORDS)) begin
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_RD: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_RD;
        if (kind_r == REQ_FREE) begin
          ram_we = 1'b1;
          if (word_r == hi_word_r) begin
            state_nxt = S_DONE;
          end else begin
            word_nxt = word_r + AW'(1);
          end
        end else if (in_word) begin
          if (wu_sts.hit) begin
            ram_we        = 1'b1;
            res_index_nxt = IDX_W'(hit_pos);
            state_nxt     = S_DONE;
          end else if (last_word) begin
            res_status_nxt = ST_NOSPACE;
            state_nxt      = S_DONE;
          end else begin
            word_nxt = word_r + AW'(1);
          end
        end else begin
          if ((word_r & blk_mask) == blk_mask) begin
            if (ok_r && wu_sts.zero) begin
              res_index_nxt = IDX_W'(blk_pos);
              fill_end_nxt  = word_r;
              word_nxt      = blk_start;
              state_nxt     = S_FILL;
            end else if (last_word) begin
              res_status_nxt = ST_NOSPACE;
              state_nxt      = S_DONE;
            end else begin
              ok_nxt   = 1'b1;
              word_nxt = word_r + AW'(1);
            end
          end else begin
            ok_nxt   = ok_r && wu_sts.zero;
            word_nxt = word_r + AW'(1);
          end
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = '1;
        if (word_r == fill_end_r) begin
          state_nxt = S_DONE;
        end else begin
          word_nxt = word_r + AW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_index_nxt  = res_index_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      word_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      word_r        <= word_nxt;
      out_valid_r   <= out_valid_nxt;
      kind_r        <= kind_nxt;
      lg_r          <= lg_nxt;
      first_word_r  <= first_word_nxt;
      first_off_r   <= first_off_nxt;
      hi_word_r     <= hi_word_nxt;
      last_off_r    <= last_off_nxt;
      last_in_map_r <= last_in_map_nxt;
      ok_r          <= ok_nxt;
      fill_end_r    <= fill_end_nxt;
      res_status_r  <= res_status_nxt;
      res_index_r   <= res_index_nxt;
      out_status_r  <= out_status_nxt;
      out_index_r   <= out_index_nxt;
    end
  end

endmodule

FILE: sim/tb_top.sv
// Testbench for the bitmap block allocator: directed and random requests checked against a page map.
`timescale 1ns / 100ps

module tb_top;
  import bba_pkg::*;

  localparam int IDLE_LIMIT = 3000;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] block_index;
  } alloc_rsp_t;

  typedef struct {
    int first;
    int count;
  } live_block_t;

  logic clk;
  logic rst_n;

  bba_req_if req_ch ();
  bba_rsp_if rsp_ch ();

  bitmap_block_allocator_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  bit          page_used [MAP_BITS];
  alloc_rsp_t  pending_rsp_q [$];
  live_block_t live_blocks [$];
  int          error_count;
  int          burst_left;
  int          idle_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
    error_count++;
  endtask

  // Page map update and response for one accepted request
  task automatic predict_request(input logic kind, input logic [CNT_W-1:0] count,
                                 input logic [IDX_W-1:0] first, output alloc_rsp_t rsp);
    int  len;
    int  hit;
    bit  clear;
    live_block_t blk;
    rsp.status      = ST_OK;
    rsp.block_index = '0;
    len = 1;
    while (len < int'(count)) len = len << 1;
    if (count == 0) begin
      rsp.status = ST_BADREQ;
    end else if (kind == REQ_ALLOC) begin
      hit = -1;
      if (len < MAP_BITS / 2) begin
        for (int base = 0; base + len <= MAP_BITS && hit < 0; base += len) begin
          clear = 1'b1;
          for (int k = base; k < base + len; k++) begin
            if (page_used[k]) clear = 1'b0;
          end
          if (clear) hit = base;
        end
      end
      if (hit < 0) begin
        rsp.status = ST_NOSPACE;
      end else begin
        for (int k = hit; k < hit + len; k++) page_used[k] = 1'b1;
        rsp.block_index = IDX_W'(hit);
        blk.first = hit;
        blk.count = int'(count);
        live_blocks.push_back(blk);
      end
    end else begin
      for (int k = int'(first); k < int'(first) + len; k++) begin
        if (k < MAP_BITS) page_used[k] = 1'b0;
      end
    end
  endtask

  // Check responses first, then queue the prediction for a request taken at this edge
  always @(posedge clk) begin : rsp_scoreboard
    alloc_rsp_t want_rsp;
    alloc_rsp_t pred_rsp;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("response with no request outstanding", int'(rsp_ch.status), -1);
      end else begin
        want_rsp = pending_rsp_q.pop_front();
        if (rsp_ch.status !== want_rsp.status)
          report_mismatch("status", int'(rsp_ch.status), int'(want_rsp.status));
        if (rsp_ch.block_index !== want_rsp.block_index)
          report_mismatch("block_index", int'(rsp_ch.block_index),
                          int'(want_rsp.block_index));
      end
    end
    if (rst_n && req_ch.valid && req_ch.ready) begin
      predict_request(req_ch.req_type, req_ch.page_count, req_ch.start_index, pred_rsp);
      pending_rsp_q.push_back(pred_rsp);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("bitmap_block_allocator_core verification failed");
        $finish;
      end
    end
  end

  // Response side back-pressure: the mode is redrawn when its random run length ends
  int rsp_mode;
  int rsp_mode_left;
  int rsp_hold;
  bit rsp_stalled;
  int rsp_cyc;

  always @(posedge clk) begin
    rsp_cyc++;
    if (rsp_mode_left == 0) begin
      rsp_mode      = $urandom_range(3);
      rsp_mode_left = $urandom_range(100, 600);
    end else begin
      rsp_mode_left--;
    end
    case (rsp_mode)
      0: rsp_ch.ready <= 1'b1;
      1: rsp_ch.ready <= ($urandom_range(1) == 1);
      2: begin
        if (rsp_hold == 0) begin
          rsp_stalled = !rsp_stalled;
          rsp_hold    = rsp_stalled ? $urandom_range(1, 24) : $urandom_range(1, 8);
        end
        rsp_hold--;
        rsp_ch.ready <= !rsp_stalled;
      end
      default: rsp_ch.ready <= ((rsp_cyc % 5) >= 2);
    endcase
  end

  task automatic send_request(input logic kind, input int count, input int first);
    int gap;
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.page_count  <= CNT_W'(count);
    req_ch.start_index <= IDX_W'(first);
    do @(posedge clk); while (!req_ch.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_ch.valid <= 1'b0;
      gap = ($urandom_range(9) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, ($urandom_range(4) == 0) ? 40 : 6);
    end
  endtask

  task automatic wait_all_responses();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_rsp_q.size() != 0);
  endtask

  function automatic int rand_alloc_count();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return $urandom_range(1, 8);
    if (sel < 85) return $urandom_range(9, 64);
    if (sel < 95) return $urandom_range(65, 256);
    return $urandom_range(257, 2047);
  endfunction

  task automatic test_bad_requests();
    send_request(REQ_ALLOC, 0, 0);
    send_request(REQ_FREE, 0, 1023);
    send_request(REQ_ALLOC, 0, 1023);
    wait_all_responses();
  endtask

  task automatic test_alloc_rounding();
    send_request(REQ_ALLOC, 1, 0);
    send_request(REQ_ALLOC, 2, 0);
    send_request(REQ_ALLOC, 3, 0);
    send_request(REQ_ALLOC, 5, 0);
    send_request(REQ_ALLOC, 255, 0);
    send_request(REQ_ALLOC, 256, 0);
    send_request(REQ_ALLOC, 257, 0);
    send_request(REQ_ALLOC, 1024, 0);
    send_request(REQ_ALLOC, 2047, 0);
    send_request(REQ_FREE, 2047, 0);
    wait_all_responses();
  endtask

  task automatic test_full_map();
    repeat (4) send_request(REQ_ALLOC, 256, 0);
    send_request(REQ_ALLOC, 1, 0);
    send_request(REQ_FREE, 1, 1023);
    send_request(REQ_ALLOC, 1, 0);
    send_request(REQ_FREE, 1024, 0);
    wait_all_responses();
  endtask

  task automatic test_free_edges();
    send_request(REQ_FREE, 16, 1023);
    send_request(REQ_FREE, 8, 100);
    send_request(REQ_ALLOC, 4, 1023);
    send_request(REQ_FREE, 4, 0);
    wait_all_responses();
  endtask

  // Mostly allocate/free pairs on live blocks, with noise frees and odd counts
  task automatic test_random_traffic(input int n_items);
    int          pick;
    int          idx;
    int          cnt;
    live_block_t blk;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_request(($urandom_range(1) == 1) ? REQ_FREE : REQ_ALLOC, 0, $urandom_range(1023));
      end else if (pick < 4) begin
        send_request(REQ_FREE, 1024, 0);
      end else if (pick < 42 || (pick < 77 && live_blocks.size() == 0)) begin
        send_request(REQ_ALLOC, rand_alloc_count(), $urandom_range(1023));
      end else if (pick < 77) begin
        idx = $urandom_range(live_blocks.size() - 1);
        blk = live_blocks[idx];
        live_blocks.delete(idx);
        cnt = ($urandom_range(5) == 0) ? $urandom_range(1, blk.count) : blk.count;
        send_request(REQ_FREE, cnt, blk.first);
      end else if (pick < 92) begin
        cnt = ($urandom_range(7) == 0) ? $urandom_range(1, 2047) : $urandom_range(1, 64);
        send_request(REQ_FREE, cnt, $urandom_range(1023));
      end else begin
        send_request(REQ_ALLOC, $urandom_range(1, 2047), $urandom_range(1023));
      end
      if (n % 400 == 399) wait_all_responses();
    end
    wait_all_responses();
  endtask

  initial begin
    rst_n              <= 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= REQ_ALLOC;
    req_ch.page_count  <= '0;
    req_ch.start_index <= '0;
    error_count = 0;
    burst_left  = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_bad_requests();
    test_alloc_rounding();
    test_full_map();
    test_free_edges();
    test_random_traffic(1350);

    repeat (80) @(posedge clk);
    if (pending_rsp_q.size() != 0)
      report_mismatch("responses never returned", 0, pending_rsp_q.size());
    if (error_count == 0) begin
      $display("bitmap_block_allocator_core verification clean");
    end else begin
      $display("bitmap_block_allocator_core verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/bba_pkg.sv
rtl/core/bba_if.sv
rtl/core/bba_ram.sv
rtl/core/bba_word_unit.sv
rtl/core/bitmap_block_allocator_core.sv
sim/tb_top.sv
